// ----- rtl/crvg_pkg.sv -----
// ----------------------------------------------------------------------------
// crvg_pkg: shared types and constants of the cylinder ring vertex generator
// Word formats on both channels, side-band records of the trig pipeline and
// the fixed-point constants of the series evaluation.
// ----------------------------------------------------------------------------
package crvg_pkg;

  localparam int unsigned MIN_SEGMENTS = 3;
  localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
  localparam logic [31:0] Q30_ONE      = 32'h4000_0000;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_e;

  typedef struct packed {
    logic signed [7:0] segment_request;
    logic [6:0]        step_index;
  } in_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [15:0] cos_value;
    logic signed [15:0] sin_value;
    logic [7:0]         bottom_vertex;
    logic [7:0]         top_vertex;
    logic               starts_quad;
  } out_t;

  // Index fields and flags worked out by the front end.
  typedef struct packed {
    logic       valid_res;
    logic [7:0] bottom_vertex;
    logic [7:0] top_vertex;
    logic       starts_quad;
  } tag_t;

  typedef struct packed {
    tag_t  tag;
    quad_e quad;
  } meta_t;

  // One stage of the series pipeline: running terms, sums and the
  // intermediate products of the divide-by-constant step.
  typedef struct packed {
    meta_t       meta;
    logic [31:0] x2;
    logic [31:0] s_term;
    logic [31:0] c_term;
    logic [33:0] s_pos;
    logic [33:0] s_neg;
    logic [33:0] c_pos;
    logic [33:0] c_neg;
    logic [31:0] s_v;
    logic [31:0] c_v;
    logic [31:0] s_q0;
    logic [31:0] c_q0;
    logic [31:0] s_qd;
    logic [31:0] c_qd;
  } stg_t;

endpackage

// ----- rtl/cylinder_ring_vertex_generator_core.sv -----
// ----------------------------------------------------------------------------
// cylinder_ring_vertex_generator_core: ring vertex generator for cylinders
// Turns a segment count and a ring step into cosine, sine, vertex indices
// and a quad-start flag, one word per cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
// Usage. Words enter on the in channel (in_valid_i, in_ready_o, in_data_i)
// and leave on the out channel (out_valid_o, out_ready_i, out_data_o), both
// under a valid/ready handshake. Every input word gives exactly one output
// word, in order. The block takes a new word in every cycle while the
// receiver keeps up, so the sustained rate is one word per cycle.
// A word passes 46 + 32 = 78 register stages when nothing stalls: one input
// stage, one queue stage, a 9-stage quadrant divider, one numerator stage,
// a 31-stage angle divider, one x squared stage, 32 Taylor series stages
// (eight terms of four stages each), one rounding stage and the output
// register.
// When the receiver stalls, the trig pipeline freezes as a whole and holds
// its output word; the two-entry queue and the input stage keep taking words
// until they are full, after which in_ready_o falls.
// Reset clears every valid flag and the queue's pointers and count at once.
// ----------------------------------------------------------------------------
module cylinder_ring_vertex_generator_core #(
  parameter int unsigned MAX_SEGMENTS  = 64,
  parameter int unsigned FRACTION_BITS = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  crvg_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output crvg_pkg::out_t  out_data_o
);
  import crvg_pkg::*;

  // Width of the clamped segment count, enough to hold MAX_SEGMENTS itself.
  localparam int unsigned CntW  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned QueW  = CntW + 7 + $bits(tag_t);

  // Front end to queue.
  logic             fe_valid, fe_ready;
  logic [CntW-1:0]  fe_cnt;
  logic [6:0]       fe_step;
  tag_t             fe_tag;

  // Queue to trig pipeline.
  logic             q_valid, q_ready;
  logic [QueW-1:0]  q_data;
  logic [CntW-1:0]  q_cnt;
  logic [6:0]       q_step;
  tag_t             q_tag;

  // The front end clamps the count and decides validity and indices.
  crvg_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .CNT_W        (CntW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (fe_valid),
    .out_ready_i (fe_ready),
    .out_cnt_o   (fe_cnt),
    .out_step_o  (fe_step),
    .out_tag_o   (fe_tag)
  );

  // The queue lets the front end run on while the trig pipeline is frozen.
  crvg_fifo #(
    .DATA_W (QueW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fe_valid),
    .in_ready_o  (fe_ready),
    .in_data_i   ({fe_cnt, fe_step, fe_tag}),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  assign {q_cnt, q_step, q_tag} = q_data;

  // The back end does all the arithmetic and owns the output register.
  crvg_back #(
    .CNT_W         (CntW),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .cnt_i       (q_cnt),
    .step_i      (q_step),
    .tag_i       (q_tag),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/crvg_front.sv -----
// ----------------------------------------------------------------------------
// crvg_front: input stage of the cylinder ring vertex generator
// Takes a word, clamps the segment count and works out the index fields.
// ----------------------------------------------------------------------------
module crvg_front #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned CNT_W        = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  crvg_pkg::in_t        in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CNT_W-1:0]     out_cnt_o,
  output logic [6:0]           out_step_o,
  output crvg_pkg::tag_t       out_tag_o
);
  import crvg_pkg::*;

  localparam logic signed [9:0] MinX = 10'(MIN_SEGMENTS);
  localparam logic signed [9:0] MaxX = 10'(MAX_SEGMENTS);

  logic signed [9:0] req_x;
  logic [9:0]        sel;
  logic [CNT_W-1:0]  cnt_d, cnt_q;
  logic [6:0]        step_q;
  tag_t              tag_d, tag_q;
  logic              vld_q, adv;

  assign req_x = 10'(in_data_i.segment_request);

  always_comb begin
    if (req_x < MinX) begin
      sel = 10'(MIN_SEGMENTS);
    end else if (req_x > MaxX) begin
      sel = 10'(MAX_SEGMENTS);
    end else begin
      sel = unsigned'(req_x);
    end
    cnt_d = CNT_W'(sel);
    tag_d.valid_res     = 10'(in_data_i.step_index) <= 10'(cnt_d);
    tag_d.starts_quad   = 10'(in_data_i.step_index) < 10'(cnt_d);
    tag_d.bottom_vertex = {in_data_i.step_index, 1'b0};
    tag_d.top_vertex    = {in_data_i.step_index, 1'b1};
  end

  assign adv        = !vld_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cnt_q  <= cnt_d;
      step_q <= in_data_i.step_index;
      tag_q  <= tag_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_cnt_o   = cnt_q;
  assign out_step_o  = step_q;
  assign out_tag_o   = tag_q;

endmodule

// ----- rtl/crvg_fifo.sv -----
// ----------------------------------------------------------------------------
// crvg_fifo: two-entry queue between front end and trig pipeline
// Decouples the stall of the back end from the input stage.
// ----------------------------------------------------------------------------
module crvg_fifo #(
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  localparam int unsigned Depth = 2;

  logic [DATA_W-1:0] slot_q [Depth];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              push, pop;

  assign in_ready_o  = cnt_q < 2'(Depth);
  assign out_valid_o = cnt_q != 2'd0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= in_data_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth)) else $error("queue count beyond depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count lost a push");

  a_full_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(Depth) |-> !push) else $error("word pushed into a full queue");

endmodule

// ----- rtl/crvg_div.sv -----
// ----------------------------------------------------------------------------
// crvg_div: pipelined restoring divider
// One quotient bit per stage; the numerator's upper part must be below the
// divisor. A side-band word travels along with each operand pair.
// ----------------------------------------------------------------------------
module crvg_div #(
  parameter int unsigned NUM_W = 9,
  parameter int unsigned QUO_W = 9,
  parameter int unsigned DEN_W = 7,
  parameter int unsigned SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             vld_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o,
  output logic [SB_W-1:0]  sb_o
);

  logic             vld_q [QUO_W];
  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [SB_W-1:0]  sb_q  [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic             vld_in;
    logic [DEN_W-1:0] rem_in, den_in;
    logic [QUO_W-1:0] lo_in;
    logic [SB_W-1:0]  sb_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign vld_in = vld_i;
      assign rem_in = DEN_W'(num_i >> QUO_W);
      assign lo_in  = num_i[QUO_W-1:0];
      assign den_in = den_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign vld_in = vld_q[i-1];
      assign rem_in = rem_q[i-1];
      assign lo_in  = lo_q[i-1];
      assign den_in = den_q[i-1];
      assign sb_in  = sb_q[i-1];
    end

    assign trial = {rem_in, lo_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= DEN_W'(ge ? trial - {1'b0, den_in} : trial);
        lo_q[i]  <= {lo_in[QUO_W-2:0], ge};
        den_q[i] <= den_in;
        sb_q[i]  <= sb_in;
      end
    end
  end

  assign vld_o = vld_q[QUO_W-1];
  assign quo_o = lo_q[QUO_W-1];
  assign rem_o = rem_q[QUO_W-1];
  assign den_o = den_q[QUO_W-1];
  assign sb_o  = sb_q[QUO_W-1];

endmodule

// ----- rtl/crvg_back.sv -----
// ----------------------------------------------------------------------------
// crvg_back: trig pipeline of the cylinder ring vertex generator
// Quadrant split, angle division, Taylor series for sine and cosine,
// rounding, quadrant mapping and the output register. Stalls as one.
// ----------------------------------------------------------------------------
module crvg_back #(
  parameter int unsigned CNT_W         = 7,
  parameter int unsigned FRACTION_BITS = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CNT_W-1:0] cnt_i,
  input  logic [6:0]       step_i,
  input  crvg_pkg::tag_t   tag_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output crvg_pkg::out_t   out_data_o
);
  import crvg_pkg::*;

  localparam int unsigned OutShift = 30 - FRACTION_BITS;
  localparam int unsigned Num2W    = 32 + CNT_W;
  localparam int unsigned Terms    = 8;
  localparam int unsigned TStg     = Terms * 4;

  logic en;

  // quadrant and remainder of 4*step / count
  logic             d1_vld;
  logic [8:0]       d1_quo;
  logic [CNT_W-1:0] d1_rem, d1_den;
  logic [$bits(tag_t)-1:0] d1_sb;

  // numerator of the in-quadrant angle division
  logic             m_vld_q;
  logic [Num2W-1:0] m_num_q;
  logic [CNT_W-1:0] m_den_q;
  meta_t            m_meta_q;

  logic              d2_vld;
  logic [30:0]       d2_quo;
  logic [$bits(meta_t)-1:0] d2_sb;

  logic [61:0] xx;
  stg_t        stg0_d;
  logic        stg_vld_q [TStg+1];
  stg_t        stg_q     [TStg+1];

  logic        r_vld_q;
  meta_t       r_meta_q;
  logic [31:0] r_s_q, r_c_q;

  logic  out_vld_q;
  out_t  out_q, out_d;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  crvg_div #(
    .NUM_W (9),
    .QUO_W (9),
    .DEN_W (CNT_W),
    .SB_W  ($bits(tag_t))
  ) u_div_quad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .num_i  ({step_i, 2'b00}),
    .den_i  (cnt_i),
    .sb_i   (tag_i),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .rem_o  (d1_rem),
    .den_o  (d1_den),
    .sb_o   (d1_sb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_num_q       <= Num2W'(HALF_PI_Q30) * Num2W'(d1_rem) + Num2W'(d1_den >> 1);
      m_den_q       <= d1_den;
      m_meta_q.tag  <= tag_t'(d1_sb);
      m_meta_q.quad <= quad_e'(d1_quo[1:0]);
    end
  end

  crvg_div #(
    .NUM_W (Num2W),
    .QUO_W (31),
    .DEN_W (CNT_W),
    .SB_W  ($bits(meta_t))
  ) u_div_angle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (m_vld_q),
    .num_i  (m_num_q),
    .den_i  (m_den_q),
    .sb_i   (m_meta_q),
    .vld_o  (d2_vld),
    .quo_o  (d2_quo),
    .rem_o  (),
    .den_o  (),
    .sb_o   (d2_sb)
  );

  assign xx = 62'(d2_quo) * 62'(d2_quo);

  // First series stage: both sums start from their leading term.
  always_comb begin
    stg0_d        = '0;
    stg0_d.meta   = meta_t'(d2_sb);
    stg0_d.x2     = xx[61:30];
    stg0_d.s_term = 32'(d2_quo);
    stg0_d.s_pos  = 34'(d2_quo);
    stg0_d.c_term = Q30_ONE;
    stg0_d.c_pos  = 34'(Q30_ONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q[0] <= 1'b0;
    end else if (en) begin
      stg_vld_q[0] <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) stg_q[0] <= stg0_d;
  end

  // Each term takes four stages: multiply by x^2, reciprocal multiply,
  // back-multiply, then correct the quotient and add it into the sums.
  for (genvar j = 0; j < TStg; j++) begin : g_term
    localparam int unsigned N  = j / 4 + 1;
    localparam int unsigned DS = (2 * N) * (2 * N + 1);
    localparam int unsigned DC = (2 * N - 1) * (2 * N);
    localparam logic [31:0] MS = 32'((64'd1 << 32) / 64'(DS));
    localparam logic [31:0] MC = 32'((64'd1 << 32) / 64'(DC));

    stg_t cur, nxt;
    assign cur = stg_q[j];

    if (j % 4 == 0) begin : g_mul
      logic [63:0] ps, pc;
      assign ps = 64'(cur.s_term) * 64'(cur.x2);
      assign pc = 64'(cur.c_term) * 64'(cur.x2);
      always_comb begin
        nxt     = cur;
        nxt.s_v = ps[61:30];
        nxt.c_v = pc[61:30];
      end
    end else if (j % 4 == 1) begin : g_recip
      logic [63:0] ps, pc;
      assign ps = 64'(cur.s_v) * 64'(MS);
      assign pc = 64'(cur.c_v) * 64'(MC);
      always_comb begin
        nxt      = cur;
        nxt.s_q0 = ps[63:32];
        nxt.c_q0 = pc[63:32];
      end
    end else if (j % 4 == 2) begin : g_back
      logic [39:0] ps, pc;
      assign ps = 40'(cur.s_q0) * 40'(DS);
      assign pc = 40'(cur.c_q0) * 40'(DC);
      always_comb begin
        nxt      = cur;
        nxt.s_qd = ps[31:0];
        nxt.c_qd = pc[31:0];
      end
    end else begin : g_fix
      logic [31:0] st, ct;
      assign st = cur.s_q0 + 32'((cur.s_v - cur.s_qd) >= 32'(DS));
      assign ct = cur.c_q0 + 32'((cur.c_v - cur.c_qd) >= 32'(DC));
      always_comb begin
        nxt        = cur;
        nxt.c_term = ct;
        if (N % 2 == 1) begin
          nxt.c_neg = cur.c_neg + 34'(ct);
        end else begin
          nxt.c_pos = cur.c_pos + 34'(ct);
        end
        // the sine series stops one term earlier than the cosine series
        if (N < Terms) begin
          nxt.s_term = st;
          if (N % 2 == 1) begin
            nxt.s_neg = cur.s_neg + 34'(st);
          end else begin
            nxt.s_pos = cur.s_pos + 34'(st);
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        stg_vld_q[j+1] <= stg_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) stg_q[j+1] <= nxt;
    end
  end

  function automatic logic [31:0] q30_round(logic [33:0] pos, logic [33:0] neg);
    logic [33:0] diff;
    logic [30:0] mag;
    logic [31:0] t;
    diff = pos - neg;
    if (neg >= pos) begin
      mag = '0;
    end else if (diff > 34'(Q30_ONE)) begin
      mag = 31'(Q30_ONE);
    end else begin
      mag = diff[30:0];
    end
    t = {mag, 1'b0} >> OutShift;
    return (t + 32'd1) >> 1;
  endfunction

  function automatic logic signed [15:0] sat16(logic [31:0] mag, logic neg);
    logic signed [15:0] v;
    if (neg) begin
      v = (mag > 32'd32768) ? -16'sd32768 : signed'(16'(32'd0 - mag));
    end else begin
      v = (mag > 32'd32767) ? 16'sd32767 : signed'(16'(mag));
    end
    return v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (en) begin
      r_vld_q <= stg_vld_q[TStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_meta_q <= stg_q[TStg].meta;
      r_s_q    <= q30_round(stg_q[TStg].s_pos, stg_q[TStg].s_neg);
      r_c_q    <= q30_round(stg_q[TStg].c_pos, stg_q[TStg].c_neg);
    end
  end

  always_comb begin
    out_d = '0;
    if (r_meta_q.tag.valid_res) begin
      out_d.valid_res     = 1'b1;
      out_d.bottom_vertex = r_meta_q.tag.bottom_vertex;
      out_d.top_vertex    = r_meta_q.tag.top_vertex;
      out_d.starts_quad   = r_meta_q.tag.starts_quad;
      case (r_meta_q.quad)
        QUAD_0: begin
          out_d.cos_value = sat16(r_c_q, 1'b0);
          out_d.sin_value = sat16(r_s_q, 1'b0);
        end
        QUAD_90: begin
          out_d.cos_value = sat16(r_s_q, 1'b1);
          out_d.sin_value = sat16(r_c_q, 1'b0);
        end
        QUAD_180: begin
          out_d.cos_value = sat16(r_c_q, 1'b1);
          out_d.sin_value = sat16(r_s_q, 1'b1);
        end
        default: begin
          out_d.cos_value = sat16(r_s_q, 1'b0);
          out_d.sin_value = sat16(r_c_q, 1'b1);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.valid_res |->
      out_q.cos_value == 16'sd0 && out_q.sin_value == 16'sd0 &&
      out_q.bottom_vertex == 8'd0 && out_q.starts_quad == 1'b0)
    else $error("rejected step carries non-zero fields");

  a_quad_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.starts_quad |-> out_q.valid_res)
    else $error("quad start flagged on a rejected step");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && $stable(out_q))
    else $error("output word changed while the receiver stalled");

endmodule
